// ===== hdl/oads_pkg.sv =====
`timescale 1ns / 1ps

package oads_pkg;

    // Serial command characters (ASCII).
    localparam logic [7:0] CHAR_AUTO    = 8'h61;  // 'a'
    localparam logic [7:0] CHAR_MANUAL  = 8'h71;  // 'q'
    localparam logic [7:0] CHAR_UP      = 8'h75;  // 'u'
    localparam logic [7:0] CHAR_DOWN    = 8'h64;  // 'd'
    localparam logic [7:0] CHAR_LEFT    = 8'h6C;  // 'l'
    localparam logic [7:0] CHAR_RIGHT   = 8'h72;  // 'r'

    // Configuration register indexes.
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 16;
    localparam logic [CFG_INDEX_W-1:0] REG_IR_NEAR      = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_IR_FAR       = 4'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SONAR_NEAR   = 4'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SONAR_FAR    = 4'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_SERIAL_PER   = 4'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_IR_PER       = 4'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_SONAR_PER    = 4'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_MOTOR_PER    = 4'd7;

    // Phase bit positions.
    localparam int PH_SERIAL = 0;
    localparam int PH_IR     = 1;
    localparam int PH_SONAR  = 2;
    localparam int PH_MOTOR  = 3;

    // Lamp levels: bit 0 red, bit 1 green.
    localparam int LAMP_RED_BIT   = 0;
    localparam int LAMP_GREEN_BIT = 1;
    localparam logic [1:0] LAMPS_OFF     = 2'b00;
    localparam logic [1:0] LAMPS_OK      = 2'b10;
    localparam logic [1:0] LAMPS_BLOCKED = 2'b01;

    localparam logic [1:0] HOLD_LIMIT = 2'd2;
    localparam logic [7:0] TICK_MAX   = 8'hFF;

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_STOP,
        CMD_FORWARD,
        CMD_BACK,
        CMD_LEFT,
        CMD_RIGHT,
        CMD_TURN
    } cmd_t;

    typedef struct packed {
        logic [7:0]  ir_near;
        logic [7:0]  ir_far;
        logic [15:0] sonar_near;
        logic [15:0] sonar_far;
        logic [7:0]  serial_period;
        logic [7:0]  ir_period;
        logic [7:0]  sonar_period;
        logic [7:0]  motor_period;
    } cfg_t;

    typedef struct packed {
        logic [7:0] serial_ticks;
        logic [7:0] ir_ticks;
        logic [7:0] sonar_ticks;
        logic [7:0] motor_ticks;
        logic [3:0] phase_bits;
        logic [1:0] hold_count;
        logic [7:0] last_byte;
        logic       autonomous;
        logic [1:0] auto_ir_class;
        logic [1:0] auto_sonar_class;
        logic [1:0] auto_comb_class;
        logic [1:0] man_ir_class;
        logic [1:0] man_sonar_class;
        logic [1:0] man_comb_class;
        logic [1:0] lamps;
    } state_t;

    typedef struct packed {
        logic       byte_taken;
        cmd_t       first_command;
        logic       first_care;
        cmd_t       second_command;
        logic       second_care;
        logic       alarm_red;
        logic       alarm_green;
        logic       autonomous_mode;
    } result_t;

    localparam cfg_t CFG_RESET = '{
        ir_near:       8'd20,
        ir_far:        8'd30,
        sonar_near:    16'd20,
        sonar_far:     16'd30,
        serial_period: 8'd1,
        ir_period:     8'd6,
        sonar_period:  8'd7,
        motor_period:  8'd1
    };

    // Autonomous banding: 0 inside the window, 1 at or beyond far, else 2.
    function automatic logic [1:0] class_auto(input logic [15:0] d,
                                              input logic [15:0] near,
                                              input logic [15:0] far);
        logic [1:0] c;
        begin
            if (d >= near && d < far)
                c = 2'd0;
            else if (d >= far)
                c = 2'd1;
            else
                c = 2'd2;
            return c;
        end
    endfunction

    // Manual banding: 2 when blocking, 1 in between, 0 when clear.
    function automatic logic [1:0] class_manual(input logic [15:0] d,
                                                input logic [15:0] near,
                                                input logic [15:0] far);
        logic [1:0] c;
        begin
            if (d <= near)
                c = 2'd2;
            else if (d < far)
                c = 2'd1;
            else
                c = 2'd0;
            return c;
        end
    endfunction

    function automatic logic [1:0] reduce_class(input logic [1:0] c);
        logic [1:0] r;
        begin
            if (c[1])
                r = 2'd2;
            else if (c[0])
                r = 2'd1;
            else
                r = 2'd0;
            return r;
        end
    endfunction

    function automatic logic [7:0] tick_advance(input logic [7:0] t);
        logic [7:0] n;
        begin
            n = (t == TICK_MAX) ? t : t + 8'd1;
            return n;
        end
    endfunction

endpackage

// ===== hdl/oads_step.sv =====
`timescale 1ns / 1ps

module oads_step
    import oads_pkg::*;
(
    input  cfg_t        cfg,
    input  state_t      cur,
    input  logic        byte_waiting,
    input  logic [7:0]  serial_byte,
    input  logic [7:0]  ir_distance,
    input  logic [15:0] sonar_distance,
    output state_t      nxt,
    output result_t     res
);

    always_comb
    begin : step_logic
        state_t     s;
        logic [7:0] t;
        logic       due;
        logic       act;
        logic       taken;
        logic       hold_stop;
        logic [1:0] c;
        cmd_t       act_cmd;
        logic       act_care;
        cmd_t       cmd0;
        cmd_t       cmd1;
        logic       care0;
        logic       care1;

        s         = cur;
        act       = 1'b0;
        taken     = 1'b0;
        hold_stop = 1'b0;
        act_cmd   = CMD_NONE;
        act_care  = 1'b0;
        cmd0      = CMD_NONE;
        cmd1      = CMD_NONE;
        care0     = 1'b0;
        care1     = 1'b0;
        c         = 2'd0;

        // Serial slot: alternates in both modes.
        t   = tick_advance(s.serial_ticks);
        due = (t >= cfg.serial_period);
        s.serial_ticks = due ? 8'd0 : t;
        if (due)
        begin
            act = !s.phase_bits[PH_SERIAL];
            s.phase_bits[PH_SERIAL] = !s.phase_bits[PH_SERIAL];
            if (act)
            begin
                s.last_byte = 8'd0;
                if (byte_waiting)
                begin
                    taken       = 1'b1;
                    s.last_byte = serial_byte;
                    if (serial_byte == CHAR_AUTO)
                        s.autonomous = 1'b1;
                    if (serial_byte == CHAR_MANUAL)
                        s.autonomous = 1'b0;
                end
            end
        end

        // IR slot.
        t   = tick_advance(s.ir_ticks);
        due = (t >= cfg.ir_period);
        s.ir_ticks = due ? 8'd0 : t;
        if (due)
        begin
            if (s.autonomous)
                s.auto_ir_class = class_auto({8'd0, ir_distance},
                                             {8'd0, cfg.ir_near}, {8'd0, cfg.ir_far});
            else
            begin
                act = !s.phase_bits[PH_IR];
                s.phase_bits[PH_IR] = !s.phase_bits[PH_IR];
                if (act)
                    s.man_ir_class = class_manual({8'd0, ir_distance},
                                                  {8'd0, cfg.ir_near}, {8'd0, cfg.ir_far});
            end
        end

        // Sonar slot, followed by the priority reduction of both combined classes.
        t   = tick_advance(s.sonar_ticks);
        due = (t >= cfg.sonar_period);
        s.sonar_ticks = due ? 8'd0 : t;
        if (due)
        begin
            if (s.autonomous)
            begin
                s.auto_sonar_class = class_auto(sonar_distance, cfg.sonar_near,
                                                cfg.sonar_far);
                s.auto_comb_class  = s.auto_ir_class | s.auto_sonar_class;
            end
            else
            begin
                act = !s.phase_bits[PH_SONAR];
                s.phase_bits[PH_SONAR] = !s.phase_bits[PH_SONAR];
                if (act)
                begin
                    s.man_sonar_class = class_manual(sonar_distance, cfg.sonar_near,
                                                     cfg.sonar_far);
                    s.man_comb_class  = s.man_ir_class | s.man_sonar_class;
                end
            end
            s.auto_comb_class = reduce_class(s.auto_comb_class);
            s.man_comb_class  = reduce_class(s.man_comb_class);
        end

        // Motor slot.
        t   = tick_advance(s.motor_ticks);
        due = (t >= cfg.motor_period);
        s.motor_ticks = due ? 8'd0 : t;
        if (due)
        begin
            if (s.autonomous)
            begin
                c = reduce_class(s.auto_comb_class);
                if (c == 2'd0)
                begin
                    s.lamps = LAMPS_OK;
                    cmd0    = CMD_FORWARD;
                    care0   = 1'b1;
                end
                else if (c == 2'd1)
                begin
                    s.lamps = LAMPS_OK;
                    cmd0    = CMD_FORWARD;
                end
                else
                begin
                    cmd0    = CMD_BACK;
                    cmd1    = CMD_TURN;
                    s.lamps = LAMPS_BLOCKED;
                end
            end
            else
            begin
                if (s.hold_count == HOLD_LIMIT)
                begin
                    hold_stop    = 1'b1;
                    s.hold_count = 2'd0;
                end
                act = !s.phase_bits[PH_MOTOR];
                s.phase_bits[PH_MOTOR] = !s.phase_bits[PH_MOTOR];
                if (act)
                begin
                    c = reduce_class(s.man_comb_class);
                    if (c != 2'd2)
                    begin
                        s.lamps = LAMPS_OK;
                        case (s.last_byte)
                            CHAR_UP:    begin act_cmd = CMD_FORWARD; act_care = c[0]; end
                            CHAR_DOWN:  begin act_cmd = CMD_BACK;    act_care = c[0]; end
                            CHAR_LEFT:  begin act_cmd = CMD_LEFT;    act_care = c[0]; end
                            CHAR_RIGHT: begin act_cmd = CMD_RIGHT;   act_care = c[0]; end
                            default:    act_cmd = CMD_STOP;
                        endcase
                    end
                    else if (s.last_byte == CHAR_DOWN)
                    begin
                        act_cmd  = CMD_BACK;
                        act_care = 1'b1;
                    end
                    else
                    begin
                        act_cmd = CMD_STOP;
                        s.lamps = LAMPS_BLOCKED;
                    end
                end
                else
                    s.hold_count = s.hold_count + 2'd1;

                // A pending hold stop goes out ahead of the phase command.
                if (hold_stop)
                begin
                    cmd0  = CMD_STOP;
                    cmd1  = act_cmd;
                    care1 = act_care;
                end
                else
                begin
                    cmd0  = act_cmd;
                    care0 = act_care;
                end
            end
        end

        nxt                 = s;
        res.byte_taken      = taken;
        res.first_command   = cmd0;
        res.first_care      = care0;
        res.second_command  = cmd1;
        res.second_care     = care1;
        res.alarm_red       = s.lamps[LAMP_RED_BIT];
        res.alarm_green     = s.lamps[LAMP_GREEN_BIT];
        res.autonomous_mode = s.autonomous;
    end

endmodule

// ===== hdl/obstacle_avoid_drive_sequencer.sv =====
`timescale 1ns / 1ps

// Obstacle-avoiding drive sequencer. Each input item is one base tick carrying
// the waiting serial byte and the latest IR and sonar distances; each tick
// yields exactly one result item with up to two drive commands, the lamp
// levels and the current mode. The block takes one item per clock cycle and
// presents its result in the cycle after acceptance: the whole tick (four slot
// timers, serial decode, distance banding and the motor decision) is resolved
// in a single pass of combinational logic that updates the state registers
// and loads the output register in the same edge. The output register is
// reloaded whenever it is empty or being drained, so in_ready only drops
// while a result is held back by out_ready. Configuration registers are
// written through the cfg channel, which is always ready; indexes beyond the
// eight defined registers are ignored. Writes should only be made while the
// block is idle.
module obstacle_avoid_drive_sequencer
    import oads_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,

    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic                   byte_waiting,
    input  logic [7:0]             serial_byte,
    input  logic [7:0]             ir_distance,
    input  logic [15:0]            sonar_distance,

    output logic                   out_valid,
    input  logic                   out_ready,
    output logic                   byte_taken,
    output logic [2:0]             first_command,
    output logic                   first_care,
    output logic [2:0]             second_command,
    output logic                   second_care,
    output logic                   alarm_red,
    output logic                   alarm_green,
    output logic                   autonomous_mode
);

    cfg_t    cfg_reg;
    state_t  state_reg;
    state_t  state_next;
    result_t res_reg;
    result_t res_next;
    logic    out_valid_reg;
    logic    in_accept;

    // The configuration port never stalls.
    assign cfg_ready = 1'b1;

    // A new item is taken whenever the output register is free or being emptied.
    assign in_ready  = !out_valid_reg || out_ready;
    assign in_accept = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= CFG_RESET;
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_IR_NEAR:    cfg_reg.ir_near       <= cfg_data[7:0];
                REG_IR_FAR:     cfg_reg.ir_far        <= cfg_data[7:0];
                REG_SONAR_NEAR: cfg_reg.sonar_near    <= cfg_data;
                REG_SONAR_FAR:  cfg_reg.sonar_far     <= cfg_data;
                REG_SERIAL_PER: cfg_reg.serial_period <= cfg_data[7:0];
                REG_IR_PER:     cfg_reg.ir_period     <= cfg_data[7:0];
                REG_SONAR_PER:  cfg_reg.sonar_period  <= cfg_data[7:0];
                REG_MOTOR_PER:  cfg_reg.motor_period  <= cfg_data[7:0];
                default:        ;
            endcase
        end
    end

    // All of the per-tick behaviour lives in the step logic.
    oads_step u_step (
        .cfg            (cfg_reg),
        .cur            (state_reg),
        .byte_waiting   (byte_waiting),
        .serial_byte    (serial_byte),
        .ir_distance    (ir_distance),
        .sonar_distance (sonar_distance),
        .nxt            (state_next),
        .res            (res_next)
    );

    // State advances only on an accepted item. Clearing the whole state also
    // leaves both lamps off.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (in_accept)
            state_reg <= state_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_accept)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    // Result payload; it needs no reset as it is qualified by out_valid.
    always_ff @(posedge clk)
    begin
        if (in_accept)
            res_reg <= res_next;
    end

    assign out_valid       = out_valid_reg;
    assign byte_taken      = res_reg.byte_taken;
    assign first_command   = res_reg.first_command;
    assign first_care      = res_reg.first_care;
    assign second_command  = res_reg.second_command;
    assign second_care     = res_reg.second_care;
    assign alarm_red       = res_reg.alarm_red;
    assign alarm_green     = res_reg.alarm_green;
    assign autonomous_mode = res_reg.autonomous_mode;

    // The manual hold counter is cleared on reaching its limit, so it never
    // reaches three.
    a_hold_bounded : assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.hold_count != 2'd3)
        else $error("motor hold counter out of range");

    // Stop and turn are always issued without the caution flag.
    a_care_clean : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (first_command == CMD_STOP || first_command == CMD_TURN)
        |-> !first_care)
        else $error("stop or turn issued with caution flag");

    // The second command slot is only used once the first is filled.
    a_cmd_order : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && second_command != CMD_NONE |-> first_command != CMD_NONE)
        else $error("second command without a first");

    // Taking an 'a' byte switches the block to autonomous mode.
    a_auto_select : assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && res_next.byte_taken && serial_byte == CHAR_AUTO
        |=> state_reg.autonomous && autonomous_mode)
        else $error("autonomous byte taken but mode not set");

    // A taken byte is remembered as the last command.
    a_byte_stored : assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && res_next.byte_taken |=> state_reg.last_byte == $past(serial_byte))
        else $error("taken byte not stored");

endmodule

// ===== tb/oads_drive_checker.sv =====
`timescale 1ns / 1ps

// Watches the three channels of the drive sequencer, keeps its own copy of
// the tick state and registers, and compares every result item in order.
module oads_drive_checker
    import oads_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,

    input  logic                   in_valid,
    input  logic                   in_ready,
    input  logic                   byte_waiting,
    input  logic [7:0]             serial_byte,
    input  logic [7:0]             ir_distance,
    input  logic [15:0]            sonar_distance,

    input  logic                   out_valid,
    input  logic                   out_ready,
    input  logic                   byte_taken,
    input  logic [2:0]             first_command,
    input  logic                   first_care,
    input  logic [2:0]             second_command,
    input  logic                   second_care,
    input  logic                   alarm_red,
    input  logic                   alarm_green,
    input  logic                   autonomous_mode,

    output int                     mismatches,
    output int                     outstanding
);

    cfg_t       regs;
    logic [7:0] slot_tmr [4];
    logic [3:0] phase_flags;
    logic [1:0] stop_hold;
    logic [7:0] held_byte;
    logic       is_auto;
    logic [1:0] a_ir_band;
    logic [1:0] a_sonar_band;
    logic [1:0] a_merged_band;
    logic [1:0] m_ir_band;
    logic [1:0] m_sonar_band;
    logic [1:0] m_merged_band;
    logic [1:0] lamp_state;
    cmd_t       cmd_slot [2];
    logic       care_slot [2];
    int         cmd_count;
    result_t    drive_results_due [$];

    function automatic logic [1:0] band_autonomous(input logic [15:0] d, lo, hi);
        if (d >= lo && d < hi)
            return 2'd0;
        if (d >= hi)
            return 2'd1;
        return 2'd2;
    endfunction

    function automatic logic [1:0] band_manual(input logic [15:0] d, lo, hi);
        if (d <= lo)
            return 2'd2;
        if (d < hi)
            return 2'd1;
        return 2'd0;
    endfunction

    function automatic logic [1:0] by_priority(input logic [1:0] c);
        return c[1] ? 2'd2 : (c[0] ? 2'd1 : 2'd0);
    endfunction

    function automatic logic [7:0] period_of(input int s);
        case (s)
            PH_SERIAL: return regs.serial_period;
            PH_IR:     return regs.ir_period;
            PH_SONAR:  return regs.sonar_period;
            default:   return regs.motor_period;
        endcase
    endfunction

    // Timers saturate rather than wrap; a slot fires once its timer reaches the period.
    function automatic bit slot_fires(input int s);
        if (slot_tmr[s] != TICK_MAX)
            slot_tmr[s] = slot_tmr[s] + 8'd1;
        if (slot_tmr[s] >= period_of(s))
        begin
            slot_tmr[s] = 8'd0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic bit phase_toggle(input int b);
        bit act;
        act = !phase_flags[b];
        phase_flags[b] = ~phase_flags[b];
        return act;
    endfunction

    function automatic void issue_cmd(input cmd_t c, input logic care);
        if (cmd_count < 2)
        begin
            cmd_slot[cmd_count] = c;
            care_slot[cmd_count] = care;
            cmd_count++;
        end
    endfunction

    function automatic result_t advance_tick(input logic waiting, input logic [7:0] ch,
                                             input logic [7:0] ir, input logic [15:0] sonar);
        result_t    r;
        logic       taken;
        logic [1:0] c;
        taken = 1'b0;
        cmd_count = 0;
        cmd_slot[0] = CMD_NONE;
        cmd_slot[1] = CMD_NONE;
        care_slot[0] = 1'b0;
        care_slot[1] = 1'b0;

        if (slot_fires(PH_SERIAL))
        begin
            if (phase_toggle(PH_SERIAL))
            begin
                held_byte = 8'd0;
                if (waiting)
                begin
                    taken = 1'b1;
                    held_byte = ch;
                    if (ch == CHAR_AUTO)
                        is_auto = 1'b1;
                    if (ch == CHAR_MANUAL)
                        is_auto = 1'b0;
                end
            end
        end

        if (slot_fires(PH_IR))
        begin
            if (is_auto)
                a_ir_band = band_autonomous({8'd0, ir}, {8'd0, regs.ir_near},
                                            {8'd0, regs.ir_far});
            else if (phase_toggle(PH_IR))
                m_ir_band = band_manual({8'd0, ir}, {8'd0, regs.ir_near}, {8'd0, regs.ir_far});
        end

        if (slot_fires(PH_SONAR))
        begin
            if (is_auto)
            begin
                a_sonar_band = band_autonomous(sonar, regs.sonar_near, regs.sonar_far);
                a_merged_band = a_ir_band | a_sonar_band;
            end
            else if (phase_toggle(PH_SONAR))
            begin
                m_sonar_band = band_manual(sonar, regs.sonar_near, regs.sonar_far);
                m_merged_band = m_ir_band | m_sonar_band;
            end
            a_merged_band = by_priority(a_merged_band);
            m_merged_band = by_priority(m_merged_band);
        end

        if (slot_fires(PH_MOTOR))
        begin
            if (is_auto)
            begin
                c = by_priority(a_merged_band);
                if (c == 2'd0)
                begin
                    lamp_state = LAMPS_OK;
                    issue_cmd(CMD_FORWARD, 1'b1);
                end
                else if (c == 2'd1)
                begin
                    lamp_state = LAMPS_OK;
                    issue_cmd(CMD_FORWARD, 1'b0);
                end
                else
                begin
                    issue_cmd(CMD_BACK, 1'b0);
                    issue_cmd(CMD_TURN, 1'b0);
                    lamp_state = LAMPS_BLOCKED;
                end
            end
            else
            begin
                if (stop_hold == HOLD_LIMIT)
                begin
                    issue_cmd(CMD_STOP, 1'b0);
                    stop_hold = 2'd0;
                end
                if (phase_toggle(PH_MOTOR))
                begin
                    c = by_priority(m_merged_band);
                    if (c <= 2'd1)
                    begin
                        lamp_state = LAMPS_OK;
                        case (held_byte)
                            CHAR_UP:    issue_cmd(CMD_FORWARD, c[0]);
                            CHAR_DOWN:  issue_cmd(CMD_BACK, c[0]);
                            CHAR_LEFT:  issue_cmd(CMD_LEFT, c[0]);
                            CHAR_RIGHT: issue_cmd(CMD_RIGHT, c[0]);
                            default:    issue_cmd(CMD_STOP, 1'b0);
                        endcase
                    end
                    else if (held_byte == CHAR_DOWN)
                        issue_cmd(CMD_BACK, 1'b1);
                    else
                    begin
                        issue_cmd(CMD_STOP, 1'b0);
                        lamp_state = LAMPS_BLOCKED;
                    end
                end
                else
                    stop_hold = stop_hold + 2'd1;
            end
        end

        r.byte_taken      = taken;
        r.first_command   = cmd_slot[0];
        r.first_care      = care_slot[0];
        r.second_command  = cmd_slot[1];
        r.second_care     = care_slot[1];
        r.alarm_red       = lamp_state[LAMP_RED_BIT];
        r.alarm_green     = lamp_state[LAMP_GREEN_BIT];
        r.autonomous_mode = is_auto;
        return r;
    endfunction

    function automatic void check_field(input string what, input int unsigned want, got);
        if (want != got)
        begin
            mismatches++;
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            regs = CFG_RESET;
            for (int s = 0; s < 4; s++)
                slot_tmr[s] = 8'd0;
            phase_flags   = 4'd0;
            stop_hold     = 2'd0;
            held_byte     = 8'd0;
            is_auto       = 1'b0;
            a_ir_band     = 2'd0;
            a_sonar_band  = 2'd0;
            a_merged_band = 2'd0;
            m_ir_band     = 2'd0;
            m_sonar_band  = 2'd0;
            m_merged_band = 2'd0;
            lamp_state    = LAMPS_OFF;
            mismatches    = 0;
            drive_results_due.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_IR_NEAR:    regs.ir_near       = cfg_data[7:0];
                    REG_IR_FAR:     regs.ir_far        = cfg_data[7:0];
                    REG_SONAR_NEAR: regs.sonar_near    = cfg_data;
                    REG_SONAR_FAR:  regs.sonar_far     = cfg_data;
                    REG_SERIAL_PER: regs.serial_period = cfg_data[7:0];
                    REG_IR_PER:     regs.ir_period     = cfg_data[7:0];
                    REG_SONAR_PER:  regs.sonar_period  = cfg_data[7:0];
                    REG_MOTOR_PER:  regs.motor_period  = cfg_data[7:0];
                    default:        ;
                endcase
            end

            // Results leave only after the edge that took their tick, so the drain is
            // handled before this edge's tick is predicted.
            if (out_valid && out_ready)
            begin
                if (drive_results_due.size() == 0)
                begin
                    mismatches++;
                    $display("%0t ns: result item with none expected, expected none, actual %0h",
                             $time, {byte_taken, first_command, first_care, second_command,
                                     second_care, alarm_red, alarm_green, autonomous_mode});
                end
                else
                begin
                    want = drive_results_due.pop_front();
                    check_field("byte_taken", want.byte_taken, byte_taken);
                    check_field("first_command", want.first_command, first_command);
                    check_field("first_care", want.first_care, first_care);
                    check_field("second_command", want.second_command, second_command);
                    check_field("second_care", want.second_care, second_care);
                    check_field("alarm_red", want.alarm_red, alarm_red);
                    check_field("alarm_green", want.alarm_green, alarm_green);
                    check_field("autonomous_mode", want.autonomous_mode, autonomous_mode);
                end
            end

            if (in_valid && in_ready)
                drive_results_due.push_back(advance_tick(byte_waiting, serial_byte,
                                                         ir_distance, sonar_distance));
        end
        outstanding = drive_results_due.size();
    end

endmodule

// ===== tb/tb_obstacle_avoid_drive_sequencer.sv =====
`timescale 1ns / 1ps

// Stimulus and verdict for the drive sequencer. Every item offered is one base
// tick; the checker beside the block predicts the result of each accepted item
// and counts mismatches, while this module only shapes the traffic and the
// register settings and decides the outcome at the end.
module tb_obstacle_avoid_drive_sequencer;
    import oads_pkg::*;

    // Indexes past the eight defined registers; writes to them must be ignored.
    // The lower one aliases register 0 in its low bits, so a partial decode shows up.
    localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED_LO = 4'd8;
    localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED_HI = 4'd15;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;

    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    logic                   in_valid = 1'b0;
    logic                   in_ready;
    logic                   byte_waiting = 1'b0;
    logic [7:0]             serial_byte = 8'd0;
    logic [7:0]             ir_distance = 8'd0;
    logic [15:0]            sonar_distance = 16'd0;

    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic                   byte_taken;
    logic [2:0]             first_command;
    logic                   first_care;
    logic [2:0]             second_command;
    logic                   second_care;
    logic                   alarm_red;
    logic                   alarm_green;
    logic                   autonomous_mode;

    int                     mismatches;
    int                     outstanding;

    // Traffic shaping, in percent of cycles, and a one-shot request for a
    // long receiver hold-off.
    int                     send_gap_pct = 21;
    int                     recv_stall_pct = 54;
    bit                     starve_req = 1'b0;

    // The register values last written, used to aim distances at the limits.
    cfg_t                   cur = CFG_RESET;

    obstacle_avoid_drive_sequencer dut (.*);

    oads_drive_checker checker_i (.*);

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // All driving happens just after a falling edge and every handshake is
    // judged at the rising edge, so the block never sees an input move near
    // the edge that samples it.

    // Offers one tick, possibly after a random gap, and returns at the falling
    // edge after it was taken. Valid is left high on return, so a following
    // call either keeps it high with a new payload or drops it for a gap.
    task automatic send_tick(input logic w, input logic [7:0] b,
                             input logic [7:0] ir, input logic [15:0] so);
        while ($urandom_range(99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid       <= 1'b1;
        byte_waiting   <= w;
        serial_byte    <= b;
        ir_distance    <= ir;
        sonar_distance <= so;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
    endtask

    task automatic put_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
    endtask

    // Registers are only touched once the block has handed back every result
    // it owes and a short pause after that has passed.
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (3) @(negedge clk);
    endtask

    // Writes all eight registers. The 8-bit ones get random upper data bits,
    // which the block has to discard.
    task automatic program_regs(input cfg_t c, input bit poke_unmapped);
        wait_drained();
        cur = c;
        if (poke_unmapped)
        begin
            put_reg(REG_UNMAPPED_LO, 16'($urandom));
            put_reg(REG_UNMAPPED_HI, 16'($urandom));
        end
        put_reg(REG_IR_NEAR, {8'($urandom), c.ir_near});
        put_reg(REG_IR_FAR, {8'($urandom), c.ir_far});
        put_reg(REG_SONAR_NEAR, c.sonar_near);
        put_reg(REG_SONAR_FAR, c.sonar_far);
        put_reg(REG_SERIAL_PER, {8'($urandom), c.serial_period});
        put_reg(REG_IR_PER, {8'($urandom), c.ir_period});
        put_reg(REG_SONAR_PER, {8'($urandom), c.sonar_period});
        put_reg(REG_MOTOR_PER, {8'($urandom), c.motor_period});
        cfg_valid <= 1'b0;
    endtask

    // Limits of sensible width with short slot periods, so every slot runs often.
    function automatic cfg_t random_regs();
        cfg_t c;
        c.ir_near       = 8'($urandom_range(120, 10));
        c.ir_far        = 8'(int'(c.ir_near) + int'($urandom_range(100, 1)));
        c.sonar_near    = 16'($urandom_range(3000, 0));
        c.sonar_far     = 16'(int'(c.sonar_near) + int'($urandom_range(3000, 1)));
        c.serial_period = 8'($urandom_range(3, 1));
        c.ir_period     = 8'($urandom_range(6, 1));
        c.sonar_period  = 8'($urandom_range(6, 1));
        c.motor_period  = 8'($urandom_range(3, 1));
        return c;
    endfunction

    // A third of the distances sit on or next to a limit, where the banding
    // changes; the rest lie between the limits, span the whole field or hit its ends.
    function automatic int pick_distance(input int lo, input int hi, input int top);
        int d;
        case ($urandom_range(5))
            0:       d = int'($urandom_range(top));
            1:       d = lo + int'($urandom_range(4)) - 2;
            2:       d = hi + int'($urandom_range(4)) - 2;
            3:       d = 0;
            4:       d = top;
            default: d = (lo < hi) ? int'($urandom_range(hi, lo)) : int'($urandom_range(top));
        endcase
        return (d < 0) ? 0 : ((d > top) ? top : d);
    endfunction

    // Receiver: random stalls, plus one long hold-off on request. While it
    // holds off, the single result register stays full and the block has to
    // refuse further ticks.
    initial
    begin
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(negedge clk);
            if (starve_req && hold_left == 0)
            begin
                hold_left = 80;
                starve_req = 1'b0;
            end
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else
                out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial
    begin
        int         roll;
        int         wait_cycles;
        logic [7:0] ch;

        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        // A few ticks with the reset register values: the serial slot and the
        // motor slot run every tick, IR and sonar only every sixth and seventh.
        send_tick(1'b0, CHAR_UP, 8'd0, 16'd0);
        send_tick(1'b1, CHAR_UP, 8'd25, 16'd25);
        send_tick(1'b1, CHAR_UP, 8'd255, 16'hFFFF);
        send_tick(1'b1, CHAR_LEFT, 8'd10, 16'd10);

        // Directed ticks with every slot running on every tick. In manual mode
        // each byte is offered twice, as the serial slot only acts on every
        // other run. Distances go blocking, in between and clear, and 'd'
        // meets a blocked path, where it backs off with caution.
        program_regs('{ir_near: 8'd20, ir_far: 8'd30, sonar_near: 16'd100,
                       sonar_far: 16'd200, serial_period: 8'd1, ir_period: 8'd1,
                       sonar_period: 8'd1, motor_period: 8'd1}, 1'b0);
        send_tick(1'b0, CHAR_UP, 8'd0, 16'd0);
        send_tick(1'b1, CHAR_UP, 8'd25, 16'd150);
        send_tick(1'b1, CHAR_UP, 8'd25, 16'd150);
        send_tick(1'b1, CHAR_DOWN, 8'd255, 16'hFFFF);
        send_tick(1'b1, CHAR_DOWN, 8'd255, 16'hFFFF);
        send_tick(1'b1, CHAR_LEFT, 8'd0, 16'd0);
        send_tick(1'b1, CHAR_LEFT, 8'd0, 16'd0);
        send_tick(1'b1, CHAR_RIGHT, 8'd31, 16'd201);
        send_tick(1'b1, CHAR_RIGHT, 8'd31, 16'd201);
        send_tick(1'b1, 8'h7A, 8'd20, 16'd100);
        send_tick(1'b1, 8'h7A, 8'd20, 16'd100);
        send_tick(1'b1, CHAR_DOWN, 8'd0, 16'd0);
        send_tick(1'b1, CHAR_DOWN, 8'd0, 16'd0);
        send_tick(1'b1, CHAR_DOWN, 8'd0, 16'd0);
        // Autonomous mode: blocked, inside the window, and clear.
        send_tick(1'b1, CHAR_AUTO, 8'd0, 16'd0);
        send_tick(1'b1, CHAR_AUTO, 8'd0, 16'd0);
        send_tick(1'b0, 8'hFF, 8'd0, 16'd0);
        send_tick(1'b0, 8'h00, 8'd25, 16'd150);
        send_tick(1'b0, CHAR_MANUAL, 8'd255, 16'hFFFF);
        send_tick(1'b1, CHAR_MANUAL, 8'd19, 16'd99);
        send_tick(1'b1, CHAR_MANUAL, 8'd30, 16'd200);
        send_tick(1'b1, 8'h80, 8'd21, 16'd101);

        // Random part in six stretches: two per traffic pattern, each with its
        // own register values. Limits in reverse order, both ends of every
        // limit, a period of zero, the longest period and ignored register
        // indexes each get a stretch.
        for (int seg = 0; seg < 6; seg++)
        begin
            case (seg)
                1: program_regs('{ir_near: 8'd255, ir_far: 8'd0, sonar_near: 16'hFFFF,
                                  sonar_far: 16'd0, serial_period: 8'd1, ir_period: 8'd1,
                                  sonar_period: 8'd1, motor_period: 8'd1}, 1'b0);
                3: program_regs('{ir_near: 8'd0, ir_far: 8'd255, sonar_near: 16'd0,
                                  sonar_far: 16'hFFFF, serial_period: 8'd0,
                                  ir_period: 8'd255, sonar_period: 8'd1,
                                  motor_period: 8'd0}, 1'b0);
                4: program_regs('{ir_near: 8'd200, ir_far: 8'd100, sonar_near: 16'd50000,
                                  sonar_far: 16'd40000, serial_period: 8'd2,
                                  ir_period: 8'd1, sonar_period: 8'd3,
                                  motor_period: 8'd1}, 1'b1);
                default: program_regs(random_regs(), 1'b0);
            endcase

            send_gap_pct   = (seg < 2) ? 21 : ((seg < 4) ? 54 : 0);
            recv_stall_pct = (seg < 2) ? 54 : ((seg < 4) ? 21 : 0);
            if (seg == 0)
                starve_req = 1'b1;

            for (int i = 0; i < 125; i++)
            begin
                // Mode and direction bytes dominate so that both modes see
                // long runs of meaningful commands; a fifth are arbitrary bytes.
                roll = $urandom_range(99);
                if (roll < 10)
                    ch = CHAR_AUTO;
                else if (roll < 20)
                    ch = CHAR_MANUAL;
                else if (roll < 35)
                    ch = CHAR_UP;
                else if (roll < 50)
                    ch = CHAR_DOWN;
                else if (roll < 65)
                    ch = CHAR_LEFT;
                else if (roll < 80)
                    ch = CHAR_RIGHT;
                else
                    ch = 8'($urandom_range(255));
                send_tick($urandom_range(99) < 75, ch,
                          8'(pick_distance(cur.ir_near, cur.ir_far, 255)),
                          16'(pick_distance(cur.sonar_near, cur.sonar_far, 65535)));
            end
        end

        // Let the last results drain, then give the block a few more cycles
        // in which any stray result item would be caught.
        in_valid <= 1'b0;
        wait_cycles = 0;
        while (outstanding != 0 && wait_cycles < 2000)
        begin
            @(negedge clk);
            wait_cycles++;
        end
        if (outstanding != 0)
            $display("FAIL");
        else
        begin
            repeat (4) @(negedge clk);
            if (mismatches == 0)
                $display("PASS");
            else
                $display("FAIL");
        end
        $finish;
    end

    // Backstop against a hung handshake: far beyond the slowest correct run.
    initial
    begin
        #2000000;
        $display("FAIL");
        $finish;
    end

endmodule
